// ===== rtl/wss_pkg.sv =====
`default_nettype none

package wss_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int OFFSET_BITS = 24;

	// bytes_seen must hold 2^OFFSET_BITS + MAX_PATTERN_BYTES.
	localparam int SEEN_BITS = OFFSET_BITS + 1;
	localparam int LEN_BITS = 5;
	localparam int WIN_IDX_BITS = $clog2(MAX_PATTERN_BYTES);
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WILDCARD_VALUE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WILDCARD_ENABLE = 3'd4;

	localparam logic STATUS_FOUND = 1'b0;
	localparam logic STATUS_ABSENT = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic                   search_status;
		logic [OFFSET_BITS-1:0] match_offset;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/wildcard_signature_scanner.sv =====
`default_nettype none

// Wildcard signature scanner.
// The byte channel (byte_valid, byte_stall, byte_item) takes one buffer byte per
// item; end_of_buffer marks the last byte of a buffer. The result channel
// (result_valid, result_stall, result_item) gives exactly one item per buffer:
// a found item with the start offset on the byte that completes the first
// match, or a not-found item with offset zero on the end-of-buffer byte.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the signature,
// its length and the wildcard settings; it must be written only while the
// block is idle, and the block itself does not enforce this. Throughput is
// one byte per cycle while no waiting result holds back the input register.
// A byte accepted into the input register is compared against the 16-byte
// window, and its result is loaded into the result register when the input
// register moves on; the receiver can take it from there. The window compare
// is combinational, between the input register and the result register.
// Reset clears the window, the byte count, the match flag and the
// configuration (length one, wildcard off); no clearing pass is needed.
// While result_stall holds a waiting result, one more byte can be accepted
// into the input register; after that byte_stall rises until the result is
// taken.
module wildcard_signature_scanner (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                byte_valid,
	output logic                                     byte_stall,
	input  wire wss_pkg::in_item_t                   byte_item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output wss_pkg::out_item_t                       result_item,
	input  wire logic                                cfg_we,
	input  wire logic [wss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [wss_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import wss_pkg::*;

	localparam logic [SEEN_BITS-1:0] SEEN_CAP =
		SEEN_BITS'((64'd1 << OFFSET_BITS) + 64'(MAX_PATTERN_BYTES));
	localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_PATTERN_BYTES);

	// Configuration registers.
	logic [63:0]         pattern_low_q;
	logic [63:0]         pattern_high_q;
	logic [LEN_BITS-1:0] pattern_length_q;
	logic [7:0]          wildcard_value_q;
	logic                wildcard_enable_q;

	// Scan state: window entry 0 holds the newest byte.
	logic [7:0]           window_q [MAX_PATTERN_BYTES];
	logic [SEEN_BITS-1:0] seen_q;
	logic                 reported_q;

	// Input register stage.
	logic     valid_s1;
	in_item_t item_s1;

	logic                 advance;
	logic [7:0]           win_next [MAX_PATTERN_BYTES];
	logic [SEEN_BITS-1:0] seen_next;
	logic [LEN_BITS-1:0]  len;
	logic [SEEN_BITS-1:0] start;
	logic [127:0]         pattern;
	logic                 window_hit;
	logic                 found;
	logic                 emit;
	out_item_t            result_next;

	// The input register moves on whenever the result register is free or is
	// being emptied in this cycle.
	assign advance = valid_s1 && !(result_valid && result_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q <= '0;
			pattern_high_q <= '0;
			pattern_length_q <= LEN_BITS'(1);
			wildcard_value_q <= '0;
			wildcard_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW: pattern_low_q <= cfg_data;
				REG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_BITS-1:0];
				REG_WILDCARD_VALUE: wildcard_value_q <= cfg_data[7:0];
				REG_WILDCARD_ENABLE: wildcard_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	// Length clamp: zero acts as one, anything above the window depth as the depth.
	always_comb begin
		priority if (pattern_length_q == '0) begin
			len = LEN_BITS'(1);
		end else if (pattern_length_q > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = pattern_length_q;
		end
	end

	assign pattern = {pattern_high_q, pattern_low_q};

	always_comb begin
		win_next[0] = item_s1.data_byte;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
			win_next[i] = window_q[i-1];
		end
	end

	assign seen_next = (seen_q < SEEN_CAP) ? seen_q + SEEN_BITS'(1) : seen_q;
	assign start = seen_next - {{(SEEN_BITS-LEN_BITS){1'b0}}, len};

	// Signature byte j lines up with the window entry len-1-j, so the first
	// signature byte meets the oldest byte of the candidate.
	always_comb begin
		logic [LEN_BITS-1:0] idx;
		logic [7:0]          sig;
		logic [7:0]          dat;
		window_hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			idx = len - LEN_BITS'(1) - LEN_BITS'(j);
			sig = pattern[8*j +: 8];
			dat = win_next[idx[WIN_IDX_BITS-1:0]];
			if ((LEN_BITS'(j) < len) && !(wildcard_enable_q && sig == wildcard_value_q)
				&& sig != dat) begin
				window_hit = 1'b0;
			end
		end
	end

	// A start above the offset limit has its top bit set and is not reported.
	assign found = !reported_q && (seen_next >= {{(SEEN_BITS-LEN_BITS){1'b0}}, len})
		&& !start[OFFSET_BITS] && window_hit;
	assign emit = found || (item_s1.end_of_buffer && !reported_q);

	always_comb begin
		if (found) begin
			result_next.search_status = STATUS_FOUND;
			result_next.match_offset = start[OFFSET_BITS-1:0];
		end else begin
			result_next.search_status = STATUS_ABSENT;
			result_next.match_offset = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= '0;
			end
			seen_q <= '0;
			reported_q <= 1'b0;
		end else if (advance) begin
			if (item_s1.end_of_buffer) begin
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					window_q[i] <= '0;
				end
				seen_q <= '0;
				reported_q <= 1'b0;
			end else begin
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					window_q[i] <= win_next[i];
				end
				seen_q <= seen_next;
				reported_q <= reported_q || found;
			end
		end
	end

	// Result register: loaded when a processed byte produces a result, cleared
	// when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_item <= result_next;
		end
	end

`ifndef SYNTH
	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_CAP)
		else $error("byte count above its saturation value");

	a_match_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && found && !item_s1.end_of_buffer) |=> reported_q)
		else $error("match flag not set after a found result");

	a_reported_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> (seen_q != '0))
		else $error("match flag set with an empty buffer");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("byte channel stalled without a waiting result");
`endif

endmodule

`default_nettype wire
